// ===== rtl/core/ultrasonic_echo_ranger_macros.svh =====
// Assertion macros shared by the ranger RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Plain property check on the rising clock, off while reset is asserted.
`define UER_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication check, off while reset is asserted.
`define UER_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define UER_ASSERT(lbl, clk, rstn, prop, msg)
`define UER_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/uer_pkg.sv =====
// Types and constants for the ultrasonic echo ranger.
// Used by every module in rtl/core; no dependencies.
package uer_pkg;

    localparam int CNT_W  = 17;
    localparam int PRE_W  = 10;
    localparam int DIST_W = 17;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SETTLE    = 3'd1,
        PH_TRIG_LOW  = 3'd2,
        PH_TRIG_HIGH = 3'd3,
        PH_RISE      = 3'd4,
        PH_FALL      = 3'd5
    } phase_t;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SETTLE = 3'd1;
    localparam logic [2:0] ST_RISE   = 3'd2;
    localparam logic [2:0] ST_FALL   = 3'd3;
    localparam logic [2:0] ST_RANGE  = 3'd4;

    localparam logic [2:0] CFG_SETTLE_TO = 3'd0;
    localparam logic [2:0] CFG_RISE_TO   = 3'd1;
    localparam logic [2:0] CFG_FALL_TO   = 3'd2;
    localparam logic [2:0] CFG_TRIG_LOW  = 3'd3;
    localparam logic [2:0] CFG_TRIG_HIGH = 3'd4;
    localparam logic [2:0] CFG_MIN_DIST  = 3'd5;
    localparam logic [2:0] CFG_MAX_DIST  = 3'd6;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } in_t;

    typedef struct packed {
        logic        trigger_out;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  status;
        logic [15:0] distance;
    } out_t;

    typedef struct packed {
        logic [15:0] settle_timeout_us;
        logic [15:0] rise_timeout_us;
        logic [15:0] fall_timeout_us;
        logic [7:0]  trigger_low_us;
        logic [7:0]  trigger_high_us;
        logic [15:0] min_distance;
        logic [15:0] max_distance;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        settle_timeout_us: 16'd2000,
        rise_timeout_us:   16'd30000,
        fall_timeout_us:   16'd30000,
        trigger_low_us:    8'd2,
        trigger_high_us:   8'd10,
        min_distance:      16'd200,
        max_distance:      16'd40000
    };

    // Control from the sequencer to the distance accumulator.
    typedef struct packed {
        logic clear;
        logic inc;
    } dist_ctl_t;

endpackage

// ===== rtl/core/uer_cfg.sv =====
// Configuration register file of the echo ranger.
// Depends on uer_pkg.
module uer_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    output uer_pkg::cfg_t       cfg
);

    uer_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= uer_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                uer_pkg::CFG_SETTLE_TO: cfg_reg.settle_timeout_us <= cfg_wdata;
                uer_pkg::CFG_RISE_TO:   cfg_reg.rise_timeout_us   <= cfg_wdata;
                uer_pkg::CFG_FALL_TO:   cfg_reg.fall_timeout_us   <= cfg_wdata;
                uer_pkg::CFG_TRIG_LOW:  cfg_reg.trigger_low_us    <= cfg_wdata[7:0];
                uer_pkg::CFG_TRIG_HIGH: cfg_reg.trigger_high_us   <= cfg_wdata[7:0];
                uer_pkg::CFG_MIN_DIST:  cfg_reg.min_distance      <= cfg_wdata;
                uer_pkg::CFG_MAX_DIST:  cfg_reg.max_distance      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/uer_dist.sv =====
// Running distance accumulator: tracks floor(count * 17 / 10) as the echo
// counter advances, so no multiply or divide is needed. Depends on uer_pkg.
module uer_dist (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  uer_pkg::dist_ctl_t            ctl,
    output logic [uer_pkg::DIST_W-1:0]    dist_val
);

    logic [uer_pkg::DIST_W-1:0] quot_reg, quot_next;
    logic [3:0]                 rem_reg, rem_next;
    logic [4:0]                 rem_sum;
    logic                       carry;

    // each count adds 1.7: one to the quotient, seven tenths to the remainder
    assign rem_sum  = {1'b0, rem_reg} + 5'd7;
    assign carry    = (rem_sum >= 5'd10);
    assign dist_val = quot_reg;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (ctl.clear) begin
            quot_next = '0;
            rem_next  = '0;
        end else if (ctl.inc) begin
            quot_next = quot_reg + {{(uer_pkg::DIST_W-2){1'b0}}, (carry ? 2'd2 : 2'd1)};
            rem_next  = carry ? 4'(rem_sum - 5'd10) : rem_sum[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quot_reg <= '0;
            rem_reg  <= '0;
        end else begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

// ===== rtl/core/uer_core.sv =====
// Measurement sequencer: phase FSM, microsecond prescaler, phase counter.
// Depends on uer_pkg, uer_dist and the assertion macro header.
`include "ultrasonic_echo_ranger_macros.svh"

module uer_core #(
    parameter int TICKS_PER_US = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  uer_pkg::in_t        in_beat,
    input  uer_pkg::cfg_t       cfg,
    output uer_pkg::out_t       res
);

    localparam int TPU_RAW = TICKS_PER_US % (2 ** uer_pkg::PRE_W);
    localparam logic [uer_pkg::PRE_W-1:0] TPU =
        (TPU_RAW == 0) ? uer_pkg::PRE_W'(1) : uer_pkg::PRE_W'(TPU_RAW);

    uer_pkg::phase_t                 phase_reg, phase_next, enter_ph;
    logic [uer_pkg::CNT_W-1:0]       cnt_reg, cnt_next, cnt_inc;
    logic [uer_pkg::PRE_W-1:0]       pre_reg, pre_next, pre_inc;
    logic                            strobe, cnt_can, enter, done;
    logic [2:0]                      status;
    logic [15:0]                     dist_out;
    logic [uer_pkg::DIST_W-1:0]      dacc;
    logic                            range_bad;
    uer_pkg::dist_ctl_t              dctl, dctl_step;

    uer_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (dctl_step),
        .dist_val (dacc)
    );

    assign dctl_step = step ? dctl : '0;

    assign range_bad = (dacc < {1'b0, cfg.min_distance})
                    || (dacc > {1'b0, cfg.max_distance})
                    || dacc[uer_pkg::DIST_W-1];

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        pre_next   = pre_reg;
        strobe     = 1'b0;
        enter      = 1'b0;
        enter_ph   = uer_pkg::PH_IDLE;
        done       = 1'b0;
        status     = uer_pkg::ST_OK;
        dist_out   = '0;
        dctl       = '0;

        pre_inc = pre_reg + uer_pkg::PRE_W'(1);
        if (phase_reg != uer_pkg::PH_IDLE) begin
            if (pre_inc >= TPU) begin
                pre_next = '0;
                strobe   = 1'b1;
            end else begin
                pre_next = pre_inc;
            end
        end
        cnt_can = strobe && (cnt_reg != uer_pkg::CNT_MAX);
        cnt_inc = cnt_reg + {{(uer_pkg::CNT_W-1){1'b0}}, cnt_can};

        unique case (phase_reg)
            uer_pkg::PH_SETTLE: begin
                if (!in_beat.echo_level) begin
                    enter    = 1'b1;
                    enter_ph = uer_pkg::PH_TRIG_LOW;
                end else if (cnt_reg > {1'b0, cfg.settle_timeout_us}) begin
                    done   = 1'b1;
                    status = uer_pkg::ST_SETTLE;
                    enter  = 1'b1;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            uer_pkg::PH_TRIG_LOW: begin
                if (cnt_inc >= {9'd0, cfg.trigger_low_us}) begin
                    enter    = 1'b1;
                    enter_ph = uer_pkg::PH_TRIG_HIGH;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            uer_pkg::PH_TRIG_HIGH: begin
                if (cnt_inc >= {9'd0, cfg.trigger_high_us}) begin
                    enter    = 1'b1;
                    enter_ph = uer_pkg::PH_RISE;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            uer_pkg::PH_RISE: begin
                if (in_beat.echo_level) begin
                    enter    = 1'b1;
                    enter_ph = uer_pkg::PH_FALL;
                end else if (cnt_reg > {1'b0, cfg.rise_timeout_us}) begin
                    done   = 1'b1;
                    status = uer_pkg::ST_RISE;
                    enter  = 1'b1;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            uer_pkg::PH_FALL: begin
                if (!in_beat.echo_level) begin
                    done  = 1'b1;
                    enter = 1'b1;
                    if (cnt_reg > {1'b0, cfg.fall_timeout_us}) begin
                        status = uer_pkg::ST_FALL;
                    end else if (range_bad) begin
                        status = uer_pkg::ST_RANGE;
                    end else begin
                        dist_out = dacc[15:0];
                    end
                end else if (cnt_reg > {1'b0, cfg.fall_timeout_us}) begin
                    done   = 1'b1;
                    status = uer_pkg::ST_FALL;
                    enter  = 1'b1;
                end else begin
                    cnt_next = cnt_inc;
                    dctl.inc = cnt_can;
                end
            end
            default: begin
                // idle and unused codes
                phase_next = uer_pkg::PH_IDLE;
                if (in_beat.start_req) begin
                    enter    = 1'b1;
                    enter_ph = uer_pkg::PH_SETTLE;
                end
            end
        endcase

        if (enter) begin
            phase_next = enter_ph;
            cnt_next   = '0;
            pre_next   = '0;
            dctl.clear = 1'b1;
        end

        res.trigger_out = (phase_next == uer_pkg::PH_TRIG_HIGH);
        res.busy_res    = (phase_next != uer_pkg::PH_IDLE);
        res.done_res    = done;
        res.status      = status;
        res.distance    = dist_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= uer_pkg::PH_IDLE;
            cnt_reg   <= '0;
            pre_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            pre_reg   <= pre_next;
        end
    end

    // a phase change always restarts the counter, prescaler and accumulator
    `UER_ASSERT_IMPL(a_phase_restart, aclk, aresetn, $past(aresetn) && (phase_reg != $past(phase_reg)), (cnt_reg == '0) && (pre_reg == '0) && (dacc == '0), "phase entered with stale counters")
    `UER_ASSERT_IMPL(a_idle_zero, aclk, aresetn, phase_reg == uer_pkg::PH_IDLE, (cnt_reg == '0) && (pre_reg == '0), "counters running while idle")
    `UER_ASSERT_IMPL(a_hold_no_step, aclk, aresetn, $past(aresetn) && !$past(step), $stable(phase_reg) && $stable(cnt_reg) && $stable(pre_reg), "state moved without an accepted beat")

endmodule

// ===== rtl/core/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger top level. Each accepted input beat is registered as a
// result beat, shown in the cycle after it is accepted. Throughput: one input beat per
// cycle; the output register lets input proceed whenever the result is taken or empty.
// Reset (aresetn, synchronous, active low): sequencer idle, counters zero,
// configuration registers at their defaults, no result pending.
// Depends on uer_pkg, uer_cfg, uer_core and the assertion macro header.
`include "ultrasonic_echo_ranger_macros.svh"

module ultrasonic_echo_ranger #(
    parameter int TICKS_PER_US = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  uer_pkg::in_t        s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output uer_pkg::out_t       m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_wdata
);

    uer_pkg::cfg_t  cfg;
    uer_pkg::out_t  res_next, res_reg;
    logic           m_valid_reg;
    logic           step;

    uer_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    uer_core #(
        .TICKS_PER_US (TICKS_PER_US)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_beat (s_data),
        .cfg     (cfg),
        .res     (res_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_next;
        end
    end

    `UER_ASSERT_IMPL(a_fail_no_dist, aclk, aresetn, m_valid_reg && (res_reg.status != uer_pkg::ST_OK), res_reg.done_res && (res_reg.distance == '0), "failed result carries a distance")
    `UER_ASSERT_IMPL(a_done_not_busy, aclk, aresetn, m_valid_reg && res_reg.done_res, !res_reg.busy_res, "result done while still busy")
    `UER_ASSERT_IMPL(a_beat_to_result, aclk, aresetn, $past(aresetn) && $past(step), m_valid_reg, "accepted beat produced no result")

endmodule
